>>> design/crc16pid_pkg.sv
// ----------------------------------------------------------------------------
// crc16pid_pkg
// shared constants and crc helper functions for the parameter crc block
// ----------------------------------------------------------------------------
package crc16pid_pkg;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned CrcWidth  = 16;

  localparam logic [CrcWidth-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcWidth-1:0] CrcPoly = 16'hA001;

  // eight reflected shift steps, unrolled into xor logic
  function automatic logic [CrcWidth-1:0] crc_shift8(input logic [CrcWidth-1:0] crc_in);
    logic [CrcWidth-1:0] c;
    c = crc_in;
    for (int k = 0; k < DataWidth; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // byte sign-extended to the crc width before the xor
  function automatic logic [CrcWidth-1:0] sign_ext_byte(input logic [DataWidth-1:0] b);
    return {{(CrcWidth-DataWidth){b[DataWidth-1]}}, b};
  endfunction

endpackage

>>> design/crc16_params_with_id_trailer_top.sv
// ----------------------------------------------------------------------------
// crc16_params_with_id_trailer_top
// running crc-16 (reflected, poly 0xa001) over parameter bytes with id trailer
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready carry one request of data_byte and
//   last_byte; bytes of one region in address order, last_byte on the final
//   output channel: out_valid / out_ready carry crc_value, one per region
//   config: cfg_write_en with cfg_write_data loads the trailer id; change it
//   only while no region is in flight
// latency: out_valid rises one cycle after the edge that accepts the last byte
// throughput: one byte per cycle; the crc update of a byte (and of the two
//   trailer bytes on the last one) is unrolled xor logic between the input
//   register and the accumulator / result register
// stall: a held result blocks only the next last byte in the input register;
//   plain bytes keep flowing, and the input register still takes a new
//   request whenever the held item can move on in the same cycle
// reset: accumulator back to 0xffff, trailer id to 0, both registers empty
// after every region the accumulator returns to 0xffff
// ----------------------------------------------------------------------------
module crc16_params_with_id_trailer_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [crc16pid_pkg::DataWidth-1:0] data_byte,
  input  logic                               last_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [crc16pid_pkg::CrcWidth-1:0]  crc_value,
  input  logic                               cfg_write_en,
  input  logic [crc16pid_pkg::CrcWidth-1:0]  cfg_write_data
);
  import crc16pid_pkg::*;

  // configuration
  logic [CrcWidth-1:0]  trailer_id;

  // input register
  logic                 stage_valid;
  logic [DataWidth-1:0] stage_data;
  logic                 stage_last;

  // running crc
  logic [CrcWidth-1:0]  crc_accum;
  logic [CrcWidth-1:0]  crc_accum_next;

  // datapath results
  logic [CrcWidth-1:0]  accum_data;
  logic [CrcWidth-1:0]  crc_final;

  logic                 stage_fire;
  logic                 in_fire;

  // a plain byte never needs the output register
  assign stage_fire = stage_valid && (!stage_last || !out_valid || out_ready);
  assign in_ready   = !stage_valid || stage_fire;
  assign in_fire    = in_valid && in_ready;

  crc16pid_fold u_fold (
    .accum      (crc_accum),
    .data       (stage_data),
    .trailer_id (trailer_id),
    .accum_data (accum_data),
    .crc_final  (crc_final)
  );

  // accumulator restarts after the last byte of a region
  always_comb begin
    crc_accum_next = crc_accum;
    if (stage_fire) begin
      crc_accum_next = stage_last ? CrcInit : accum_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trailer_id <= '0;
    end else if (cfg_write_en) begin
      trailer_id <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      crc_accum   <= CrcInit;
    end else begin
      crc_accum <= crc_accum_next;
      if (in_fire) begin
        stage_valid <= 1'b1;
      end else if (stage_fire) begin
        stage_valid <= 1'b0;
      end
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_data <= data_byte;
      stage_last <= last_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire && stage_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_last) begin
      crc_value <= crc_final;
    end
  end

endmodule

>>> design/crc16pid_fold.sv
// ----------------------------------------------------------------------------
// crc16pid_fold
// one data byte into the running crc, plus the project id trailer
// ----------------------------------------------------------------------------
module crc16pid_fold (
  input  logic [crc16pid_pkg::CrcWidth-1:0]  accum,
  input  logic [crc16pid_pkg::DataWidth-1:0] data,
  input  logic [crc16pid_pkg::CrcWidth-1:0]  trailer_id,
  output logic [crc16pid_pkg::CrcWidth-1:0]  accum_data,
  output logic [crc16pid_pkg::CrcWidth-1:0]  crc_final
);
  import crc16pid_pkg::*;

  logic [CrcWidth-1:0] after_low;

  assign accum_data = crc_shift8(accum ^ {{(CrcWidth-DataWidth){1'b0}}, data});
  assign after_low  = crc_shift8(accum_data ^ sign_ext_byte(trailer_id[DataWidth-1:0]));
  assign crc_final  = crc_shift8(after_low ^ sign_ext_byte(trailer_id[CrcWidth-1:DataWidth]));

endmodule

>>> design/crc16pid_checker.sv
// ----------------------------------------------------------------------------
// crc16pid_checker
// port-level checks for the parameter crc block, bound to the top level
// ----------------------------------------------------------------------------
module crc16pid_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               last_byte,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [crc16pid_pkg::CrcWidth-1:0]  crc_value
);
  import crc16pid_pkg::*;

  // nothing comes out right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(crc_value))
    else $error("result changed while stalled");

  // with the output register empty the input side never stalls
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a fresh result follows an accepted last byte
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_byte, 2))
    else $error("result without a last byte");

endmodule

bind crc16_params_with_id_trailer_top crc16pid_checker u_crc16pid_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .crc_value (crc_value)
);

>>> dv/tb_crc16_params_with_id_trailer_top.sv
// ----------------------------------------------------------------------------
// tb_crc16_params_with_id_trailer_top
// self-checking bench for the parameter crc with project id trailer
// ----------------------------------------------------------------------------
// a short table of directed requests comes first: single-byte regions,
// all-zero and all-ones project ids, trailer bytes with and without bit 7,
// and a project id load in the middle of a region. random regions follow,
// mostly short, a few long, with project id loads between regions. each crc
// result is checked in arrival order against the bench model or known_crc.
// ----------------------------------------------------------------------------
module tb_crc16_params_with_id_trailer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crc16pid_pkg::*;

  localparam int unsigned MaxShown      = 10;
  localparam int unsigned DrainCycles   = 4;   // input register plus result register
  localparam int unsigned BytesPerPhase = 305;
  localparam int unsigned DirectedRows  = 20;

  // one row of the directed table; known_crc is used only when has_crc is set
  typedef struct packed {
    logic                wr_id;
    logic [CrcWidth-1:0] id_val;
    logic [DataWidth-1:0] data;
    logic                last;
    logic                has_crc;
    logic [CrcWidth-1:0] known_crc;
  } crc_row_t;

  logic                 clk            = 1'b0;
  logic                 rst            = 1'b1;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [DataWidth-1:0] data_byte      = '0;
  logic                 last_byte      = 1'b0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [CrcWidth-1:0]  crc_value;
  logic                 cfg_write_en   = 1'b0;
  logic [CrcWidth-1:0]  cfg_write_data = '0;

  // bench-side copy of the block state
  logic [CrcWidth-1:0] crc_running = CrcInit;
  logic [CrcWidth-1:0] trailer_id  = '0;

  // crc results still owed by the block, oldest first
  logic [CrcWidth-1:0] crc_pending [$];

  int unsigned in_gap_pct    = 0;
  int unsigned out_stall_pct = 0;
  int unsigned error_count   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned regions_sent  = 0;
  int unsigned crc_checked   = 0;
  int unsigned id_loads      = 0;

  // directed requests
  //   rows 0-1: single-byte regions right after reset and with an all-ones id
  //   rows 2-4: trailer low byte has bit 7 set, high byte clear
  //   rows 5-6: trailer high byte has bit 7 set, low byte clear
  //   rows 7-13: walking one across data bits 0 to 6
  //   rows 16-18: project id reloaded while a region is half done
  crc_row_t directed_rows [DirectedRows] = '{
    '{1'b0, 16'h0000, 8'hFF, 1'b1, 1'b1, 16'hF041},
    '{1'b1, 16'hFFFF, 8'h00, 1'b1, 1'b1, 16'h30CF},
    '{1'b1, 16'h0080, 8'h00, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h80, 1'b1, 1'b0, 16'h0000},
    '{1'b1, 16'h8000, 8'h55, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'hAA, 1'b1, 1'b0, 16'h0000},
    '{1'b1, 16'h7F7F, 8'h01, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h02, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h04, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h08, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h10, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h20, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h40, 1'b1, 1'b0, 16'h0000},
    '{1'b1, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'hFF, 1'b1, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h12, 1'b0, 1'b0, 16'h0000},
    '{1'b0, 16'h0000, 8'h34, 1'b0, 1'b0, 16'h0000},
    '{1'b1, 16'h1234, 8'h56, 1'b1, 1'b0, 16'h0000},
    '{1'b1, 16'h0000, 8'h00, 1'b1, 1'b0, 16'h0000}
  };

  crc16_params_with_id_trailer_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .crc_value      (crc_value),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2ms;
    $display("tb_crc16_params_with_id_trailer_top NOT OK");
    $finish;
  end

  // xor a 16-bit value into the crc, then eight reflected shift steps
  function automatic logic [CrcWidth-1:0] crc_fold(input logic [CrcWidth-1:0] crc_in,
                                                   input logic [CrcWidth-1:0] fold_in);
    logic [CrcWidth-1:0] c;
    c = crc_in ^ fold_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // trailer bytes are folded in sign-extended
  function automatic logic [CrcWidth-1:0] widen_signed(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

  // update the crc model with an accepted byte; a last byte owes one result
  task automatic note_accepted(input logic [DataWidth-1:0] d, input logic l,
                               input logic has_crc, input logic [CrcWidth-1:0] known_crc);
    logic [CrcWidth-1:0] c;
    c = crc_fold(crc_running, {8'h00, d});
    bytes_sent++;
    if (!l) begin
      crc_running = c;
    end else begin
      c = crc_fold(c, widen_signed(trailer_id[7:0]));
      c = crc_fold(c, widen_signed(trailer_id[15:8]));
      crc_pending.push_back(has_crc ? known_crc : c);
      crc_running = CrcInit;
      regions_sent++;
    end
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MaxShown) begin
      $display("%s", msg);
    end
  endtask

  // one byte request; valid stays up after acceptance so back-to-back
  // requests never drop it, every path that lets time pass lowers it first
  task automatic send_byte(input logic [DataWidth-1:0] d, input logic l,
                           input logic has_crc, input logic [CrcWidth-1:0] known_crc);
    while ($urandom_range(99, 0) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    note_accepted(d, l, has_crc, known_crc);
  endtask

  // wait for every owed result, then let plain bytes finish in the pipe
  task automatic settle_block();
    in_valid <= 1'b0;
    while (crc_pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_trailer_id(input logic [CrcWidth-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    trailer_id = v;
    id_loads++;
  endtask

  function automatic logic [CrcWidth-1:0] pick_trailer_id();
    case ($urandom_range(4, 0))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8080;
      3:       return 16'h7F7F;
      default: return CrcWidth'($urandom_range(65535, 0));
    endcase
  endfunction

  // random regions: mostly short, some medium, a few long
  task automatic run_random_regions(input int unsigned byte_goal);
    int unsigned start_count;
    int unsigned region_len;
    start_count = bytes_sent;
    while (bytes_sent - start_count < byte_goal) begin
      if ($urandom_range(9, 0) == 0) begin
        settle_block();
        load_trailer_id(pick_trailer_id());
      end
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4, 5: region_len = $urandom_range(4, 1);
        6, 7, 8:          region_len = $urandom_range(16, 5);
        default:          region_len = $urandom_range(48, 17);
      endcase
      for (int unsigned k = 0; k < region_len; k++) begin
        send_byte(DataWidth'($urandom_range(255, 0)), k == region_len - 1, 1'b0, '0);
      end
    end
  endtask

  // result side: check at each accepted crc, then pick next cycle's ready
  initial begin
    logic [CrcWidth-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (crc_pending.size() == 0) begin
          flag_error($sformatf("unexpected crc result %04h with no region pending",
                               crc_value));
        end else begin
          want = crc_pending.pop_front();
          crc_checked++;
          if (crc_value !== want) begin
            flag_error($sformatf("crc_value mismatch: expected %04h got %04h",
                                 want, crc_value));
          end
        end
      end
      out_ready <= ($urandom_range(99, 0) >= out_stall_pct);
    end
  end

  // request side and sequencing
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, run with the first idling mix
    in_gap_pct    = 34;
    out_stall_pct = 45;
    for (int i = 0; i < DirectedRows; i++) begin
      if (directed_rows[i].wr_id) begin
        settle_block();
        load_trailer_id(directed_rows[i].id_val);
      end
      send_byte(directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].has_crc, directed_rows[i].known_crc);
    end

    // three random phases: receiver idles more, sender idles more, no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_gap_pct    = 34;
          out_stall_pct = 45;
        end
        1: begin
          in_gap_pct    = 45;
          out_stall_pct = 34;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      settle_block();
      load_trailer_id(pick_trailer_id());
      run_random_regions(BytesPerPhase);
    end

    settle_block();
    repeat (DrainCycles) @(posedge clk);
    if (crc_pending.size() != 0) begin
      flag_error($sformatf("%0d crc results never arrived", crc_pending.size()));
    end

    $display("sent %0d bytes in %0d regions over %0d project id loads",
             bytes_sent, regions_sent, id_loads);
    $display("checked %0d crc results, %0d errors", crc_checked, error_count);
    if (error_count == 0) begin
      $display("tb_crc16_params_with_id_trailer_top OK");
    end else begin
      $display("tb_crc16_params_with_id_trailer_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/crc16pid_pkg.sv
design/crc16pid_fold.sv
design/crc16_params_with_id_trailer_top.sv
design/crc16pid_checker.sv
dv/tb_crc16_params_with_id_trailer_top.sv
